// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/core/mbd_pkg.sv -----
// ----------------------------------------------------------------------------
// mbd_pkg
// constants for the multi-button debouncer
// ----------------------------------------------------------------------------
package mbd_pkg;

   localparam int NUM_BUTTONS    = 3;
   localparam int RAW_WIDTH      = 3;
   localparam int IDX_WIDTH      = 2;
   localparam int TIME_WIDTH     = 32;
   localparam int DEBOUNCE_WIDTH = 16;

   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = DEBOUNCE_WIDTH'(50);

endpackage

// ----- rtl/core/multi_button_debouncer.sv -----
// ----------------------------------------------------------------------------
// multi_button_debouncer
// timestamp debouncer for active-low buttons, reports the first new press
// ----------------------------------------------------------------------------
//
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  req_raw_levels, req_now_ms
// rsp_      out        rsp_valid/rsp_stall  rsp_press_found, rsp_button_index
// csr_      in         csr_write_enable     csr_write_data (debounce time, ms)
//
// one request per cycle while not stalled, via the input then the result register
// the per-button compare and priority pick sit between input and result register
// each request updates the button state as it moves into the result register
// reset is synchronous and leaves every button released, debounce time 50 ms
// a stalled result holds; the input register still fills behind it
//
`include "assert_macros.svh"

module multi_button_debouncer
   import mbd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [RAW_WIDTH-1:0]      req_raw_levels,
   input  logic [TIME_WIDTH-1:0]     req_now_ms,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_press_found,
   output logic [IDX_WIDTH-1:0]      rsp_button_index,
   // configuration
   input  logic                      csr_write_enable,
   input  logic [DEBOUNCE_WIDTH-1:0] csr_write_data
);

   // configuration register
   logic [DEBOUNCE_WIDTH-1:0] debounce_time_ff;

   // input register
   logic                  in_valid_ff;
   logic [RAW_WIDTH-1:0]  raw_levels_ff;
   logic [TIME_WIDTH-1:0] now_ms_ff;

   // per-button state
   logic [NUM_BUTTONS-1:0] last_raw_ff, last_raw_in;
   logic [NUM_BUTTONS-1:0] stable_level_ff, stable_level_in;
   logic [TIME_WIDTH-1:0]  change_time_ff [NUM_BUTTONS];
   logic [TIME_WIDTH-1:0]  change_time_in [NUM_BUTTONS];

   // result register
   logic                 rsp_valid_ff;
   logic                 press_found_ff, press_found_in;
   logic [IDX_WIDTH-1:0] button_index_ff, button_index_in;

   logic                   out_ready;
   logic                   load;
   logic [NUM_BUTTONS-1:0] raw_pad;
   logic [TIME_WIDTH-1:0]  debounce_wide;

   // result register frees when empty or when its result is taken
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   // the held request moves on, and updates the state, on this edge
   assign load      = in_valid_ff && out_ready;
   assign req_stall = in_valid_ff && !out_ready;

   // buttons beyond the input bits read as released
   assign raw_pad = NUM_BUTTONS'({{NUM_BUTTONS{1'b1}}, raw_levels_ff});
   assign debounce_wide =
      {{(TIME_WIDTH-DEBOUNCE_WIDTH){1'b0}}, debounce_time_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= DEBOUNCE_RESET;
      end else if (csr_write_enable) begin
         debounce_time_ff <= csr_write_data;
      end
   end

   // input register: takes a request whenever it is not stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         raw_levels_ff <= req_raw_levels;
         now_ms_ff     <= req_now_ms;
      end
   end

   // all buttons in parallel, then a priority pick on the lowest new press;
   // buttons above the pick are left untouched for this poll
   always_comb begin
      logic                  raw_bit;
      logic [TIME_WIDTH-1:0] change_t;
      logic [TIME_WIDTH-1:0] elapsed;
      logic                  settle;
      logic                  blocked;
      last_raw_in     = last_raw_ff;
      stable_level_in = stable_level_ff;
      change_time_in  = change_time_ff;
      press_found_in  = 1'b0;
      button_index_in = '0;
      blocked         = 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         raw_bit  = raw_pad[b];
         // a fresh edge restarts the timer at this poll
         change_t = (raw_bit != last_raw_ff[b]) ? now_ms_ff : change_time_ff[b];
         // wrapping difference, compared unsigned
         elapsed  = now_ms_ff - change_t;
         settle   = (elapsed >= debounce_wide) && (raw_bit != stable_level_ff[b]);
         if (!blocked) begin
            last_raw_in[b]    = raw_bit;
            change_time_in[b] = change_t;
            if (settle) begin
               stable_level_in[b] = raw_bit;
               // a settled release only updates the level, the scan goes on
               if (!raw_bit) begin
                  press_found_in  = 1'b1;
                  button_index_in = IDX_WIDTH'(b);
                  blocked         = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff     <= '1;
         stable_level_ff <= '1;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            change_time_ff[b] <= '0;
         end
      end else if (load) begin
         last_raw_ff     <= last_raw_in;
         stable_level_ff <= stable_level_in;
         change_time_ff  <= change_time_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         press_found_ff  <= press_found_in;
         button_index_ff <= button_index_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_press_found  = press_found_ff;
   assign rsp_button_index = button_index_ff;

   // checks
   `ASSERT_PROP(a_idle_index, clock, reset, (rsp_valid_ff && !press_found_ff) |-> (button_index_ff == '0), "index set without a press")
   `ASSERT_PROP(a_press_stable, clock, reset, load |=> (!press_found_ff || ((button_index_ff < IDX_WIDTH'(NUM_BUTTONS)) && !stable_level_ff[button_index_ff])), "reported button not stable low")
   `ASSERT_PROP(a_stall_full, clock, reset, req_stall |-> in_valid_ff, "stall with empty input register")
   `ASSERT_PROP(a_time_with_edge, clock, reset, !$stable(change_time_ff[0]) |-> !$stable(last_raw_ff[0]), "timestamp moved without a raw edge")
   `ASSERT_NEVER(a_state_quiet, clock, reset, !$past(load) && !$stable(stable_level_ff), "stable level moved without a request")

endmodule

// ----- verif/multi_button_debouncer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_button_debouncer_tb
// self-checking bench for the timestamp debouncer
// queued polls feed a clocked driver, a scan model predicts every request
// a clocked monitor checks results in order under varying stall patterns
// directed polls for boundary times, wrap, bounces, early stop and release
// random polls follow, with one long receiver hold-off
// ----------------------------------------------------------------------------
module multi_button_debouncer_tb;
   import mbd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLDOFF_CYCLES = 300;

   typedef struct packed {
      logic [RAW_WIDTH-1:0]  raw_levels;
      logic [TIME_WIDTH-1:0] now_ms;
   } poll_type;

   typedef struct packed {
      logic                 press_found;
      logic [IDX_WIDTH-1:0] button_index;
   } press_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // block inputs, all known from time zero
   logic                      req_valid = 1'b0;
   logic [RAW_WIDTH-1:0]      req_raw_levels = '1;
   logic [TIME_WIDTH-1:0]     req_now_ms = '0;
   logic                      rsp_stall = 1'b0;
   logic                      csr_write_enable = 1'b0;
   logic [DEBOUNCE_WIDTH-1:0] csr_write_data = '0;

   // block outputs
   logic                 req_stall;
   logic                 rsp_valid;
   logic                 rsp_press_found;
   logic [IDX_WIDTH-1:0] rsp_button_index;

   // scan model state, one entry per button
   logic                      seen_raw [NUM_BUTTONS];
   logic                      settled_level [NUM_BUTTONS];
   logic [TIME_WIDTH-1:0]     changed_at [NUM_BUTTONS];
   logic [DEBOUNCE_WIDTH-1:0] model_hold_time = DEBOUNCE_RESET;

   poll_type  poll_queue [$];
   press_type press_expected [$];

   int error_count = 0;
   int polls_accepted = 0;
   int cycle_count = 0;
   int unsigned send_idle_pct = 32;
   int unsigned recv_idle_pct = 64;
   logic long_hold = 1'b0;

   // running stimulus state for the random polls
   logic [RAW_WIDTH-1:0]  stim_levels = '1;
   logic [TIME_WIDTH-1:0] stim_time = '0;

   multi_button_debouncer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_levels   (req_raw_levels),
      .req_now_ms       (req_now_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_press_found  (rsp_press_found),
      .rsp_button_index (rsp_button_index),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // one line per mismatch, counted for the final verdict
   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   // walk the buttons in index order, updating the model state; the first
   // button that settles low is reported and the scan stops there
   function automatic press_type scan_buttons(input logic [RAW_WIDTH-1:0] levels,
                                              input logic [TIME_WIDTH-1:0] now);
      press_type found;
      logic raw;
      logic [TIME_WIDTH-1:0] elapsed;
      bit stopped;
      found = '0;
      stopped = 1'b0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         if (!stopped) begin
            // buttons beyond the input width read as released
            raw = (b < RAW_WIDTH) ? levels[b] : 1'b1;
            if (raw != seen_raw[b]) begin
               seen_raw[b] = raw;
               changed_at[b] = now;
            end
            // elapsed time wraps modulo 2^32, compared unsigned
            elapsed = now - changed_at[b];
            if (elapsed >= TIME_WIDTH'(model_hold_time) && raw != settled_level[b]) begin
               settled_level[b] = raw;
               // a settled release reports nothing and the scan goes on
               if (raw == 1'b0) begin
                  found.press_found = 1'b1;
                  found.button_index = IDX_WIDTH'(b);
                  stopped = 1'b1;
               end
            end
         end
      end
      return found;
   endfunction

   // driver: predict on acceptance, then offer the next poll or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            seen_raw[b] = 1'b1;
            settled_level[b] = 1'b1;
            changed_at[b] = '0;
         end
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            press_expected.push_back(scan_buttons(req_raw_levels, req_now_ms));
            polls_accepted <= polls_accepted + 1;
         end
         // a new offer is only decided once the previous request has gone
         if (poll_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            poll_type p;
            p = poll_queue.pop_front();
            req_valid <= 1'b1;
            req_raw_levels <= p.raw_levels;
            req_now_ms <= p.now_ms;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      press_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (press_expected.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: found %0b index %0d",
                                         rsp_press_found, rsp_button_index));
            end else begin
               want = press_expected.pop_front();
               if (rsp_press_found !== want.press_found)
                  report_mismatch($sformatf("press_found %0b, predicted %0b",
                                            rsp_press_found, want.press_found));
               if (rsp_button_index !== want.button_index)
                  report_mismatch($sformatf("button_index %0d, predicted %0d",
                                            rsp_button_index, want.button_index));
            end
         end
      end
      rsp_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("multi_button_debouncer_tb: errors");
         $finish;
      end
   end

   // long receiver hold-off once the random part is under way, so the block
   // fills and pushes back on its input
   initial begin
      wait (polls_accepted >= 400);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic push_poll(input logic [RAW_WIDTH-1:0] levels,
                            input logic [TIME_WIDTH-1:0] now);
      poll_type p;
      p.raw_levels = levels;
      p.now_ms = now;
      poll_queue.push_back(p);
   endtask

   // wait until every request has been sent and every result has come back
   task automatic wait_until_idle();
      while (poll_queue.size() != 0 || req_valid || press_expected.size() != 0)
         @(posedge clock);
      // extra margin after the pipeline has drained
      repeat (4) @(posedge clock);
   endtask

   // only called while idle, from just after a rising edge
   task automatic write_debounce(input logic [DEBOUNCE_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_hold_time = value;
   endtask

   // mostly steady levels with occasional flips and bounces; time steps are
   // scaled to the debounce time so that presses settle, plus a little noise
   task automatic push_random_polls(input int count, input int unsigned dt);
      logic [TIME_WIDTH-1:0] step;
      int unsigned pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 3) begin
            push_poll(RAW_WIDTH'($urandom), $urandom);
         end else begin
            if (pick < 35)
               stim_levels[$urandom_range(RAW_WIDTH-1)] ^= 1'b1;
            if (pick == 99) begin
               // land just short of the wrap point
               stim_time = '1 - TIME_WIDTH'($urandom_range(3 * dt + 10));
            end else begin
               if (pick < 67)
                  step = TIME_WIDTH'($urandom_range(dt / 4 + 1));
               else
                  step = TIME_WIDTH'(dt + $urandom_range(dt / 2 + 2));
               stim_time += step;
            end
            push_poll(stim_levels, stim_time);
         end
      end
   endtask

   initial begin
      int unsigned dt;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset debounce time of 50 ms
      push_poll(3'b111, 32'd0);
      push_poll(3'b110, 32'd10);          // button 0 goes low
      push_poll(3'b110, 32'd60);          // exactly 50 ms later, press on 0
      push_poll(3'b000, 32'd70);
      push_poll(3'b000, 32'd120);         // press on 1, button 2 left for later
      push_poll(3'b000, 32'd121);         // press on 2
      push_poll(3'b111, 32'd200);
      push_poll(3'b111, 32'd250);         // releases settle silently
      push_poll(3'b011, 32'd300);         // bounce on button 2
      push_poll(3'b111, 32'd320);
      push_poll(3'b011, 32'd340);
      push_poll(3'b011, 32'd389);         // one ms short
      push_poll(3'b011, 32'd390);         // press on 2
      push_poll(3'b101, 32'hFFFF_FFF0);   // change just before the wrap
      push_poll(3'b101, 32'hFFFF_FFFF);
      push_poll(3'b101, 32'h0000_0022);   // 50 ms across the wrap, press on 1
      push_poll(3'b111, 32'h0000_0040);
      push_poll(3'b010, 32'h0000_0100);   // buttons 0 and 2 low together
      push_poll(3'b010, 32'h0000_0132);   // press on 0 only
      push_poll(3'b010, 32'h0000_0133);   // press on 2
      wait_until_idle();

      // zero debounce time settles in the same poll
      write_debounce('0);
      push_poll(3'b111, $urandom);
      push_poll(3'b110, $urandom);
      push_poll(3'b000, $urandom);
      push_poll(3'b000, $urandom);
      wait_until_idle();

      // longest debounce time
      write_debounce('1);
      push_poll(3'b111, 32'd1000);
      push_poll(3'b011, 32'd2000);
      push_poll(3'b011, 32'd67534);
      push_poll(3'b011, 32'd67535);
      wait_until_idle();

      // random part in six blocks, each with its own debounce time
      for (int blk = 0; blk < 6; blk++) begin
         case (blk)
            0: dt = 5;
            1: dt = 0;
            2: dt = $urandom_range(1, 100);
            3: dt = 65535;
            4: dt = 32'(DEBOUNCE_RESET);
            default: dt = $urandom_range(0, 65535);
         endcase
         // sender idles lightly first, then the receiver, then neither
         if (blk < 2) begin
            send_idle_pct = 32;
            recv_idle_pct = 64;
         end else if (blk < 4) begin
            send_idle_pct = 64;
            recv_idle_pct = 32;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_debounce(DEBOUNCE_WIDTH'(dt));
         push_random_polls(333, dt);
         wait_until_idle();
      end

      repeat (10) @(posedge clock);
      if (error_count == 0 && press_expected.size() == 0) begin
         $display("multi_button_debouncer_tb: clean");
      end else begin
         $display("multi_button_debouncer_tb: errors");
      end
      $finish;
   end

endmodule
